// ===== rtl/jsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// jsbd_pkg
// Shared types, constants and helpers for the start-of-frame bit depth
// scanner.
// ----------------------------------------------------------------------------
package jsbd_pkg;

    // One input byte with its framing flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    // One result: bits per pixel and the found flag
    typedef struct packed {
        logic [15:0] bits_per_pixel;
        logic        found;
    } out_item_t;

    // Marker byte values
    localparam logic [7:0] MARKER_SYNC = 8'hFF;
    localparam logic [7:0] SOF_LO_MIN  = 8'hC0;
    localparam logic [7:0] SOF_LO_MAX  = 8'hCF;
    localparam logic [7:0] MARKER_DHT  = 8'hC4;
    localparam logic [7:0] MARKER_JPG  = 8'hC8;

    // Bytes between the precision byte and the component count byte
    localparam logic [15:0] SOF_GAP = 16'd4;

    // Start-of-frame low byte: C0..CF except the Huffman table and JPG codes
    function automatic logic is_sof_low(input logic [7:0] lo);
        return (lo >= SOF_LO_MIN) && (lo <= SOF_LO_MAX) &&
               (lo != MARKER_DHT) && (lo != MARKER_JPG);
    endfunction

endpackage

// ===== rtl/jsbd_in_stage.sv =====
// ----------------------------------------------------------------------------
// jsbd_in_stage
// Input register: captures one item and releases it to the parser when the
// result register can take whatever it produces.
// ----------------------------------------------------------------------------
module jsbd_in_stage
    import jsbd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     step,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Accept when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || advance;
    assign step    = valid_reg && advance;
    assign item    = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until a new item is taken
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/jsbd_parser.sv =====
// ----------------------------------------------------------------------------
// jsbd_parser
// Marker segment walker: one state update per byte, and the result that the
// byte causes, if any.
// ----------------------------------------------------------------------------
module jsbd_parser
    import jsbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res_item
);

    typedef enum logic [3:0] {
        PH_SKIP0,
        PH_SKIP1,
        PH_MHI,
        PH_MLO,
        PH_LHI,
        PH_LLO,
        PH_SEGSKIP,
        PH_PREC,
        PH_SOFSKIP,
        PH_COMP,
        PH_DONE
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [15:0] count_reg,     count_next;
    logic [7:0]  marker_reg,    marker_next;
    logic [15:0] length_reg,    length_next;
    logic [7:0]  precision_reg, precision_next;
    logic        done_reg,      done_next;

    always_comb begin
        phase_t      ph;
        logic [15:0] len_full;
        logic [15:0] cnt_dec;

        // Restart on the first byte of an image
        ph             = item.first_byte ? PH_SKIP0 : phase_reg;
        count_next     = item.first_byte ? '0 : count_reg;
        marker_next    = item.first_byte ? '0 : marker_reg;
        length_next    = item.first_byte ? '0 : length_reg;
        precision_next = item.first_byte ? '0 : precision_reg;
        done_next      = item.first_byte ? 1'b0 : done_reg;
        phase_next     = ph;
        res_valid      = 1'b0;
        res_item       = '0;
        len_full       = {length_next[15:8], item.data_byte};
        cnt_dec        = count_next - 16'd1;

        unique case (ph)
            PH_SKIP0: begin
                phase_next = PH_SKIP1;
            end
            PH_SKIP1: begin
                phase_next = PH_MHI;
            end
            PH_MHI: begin
                marker_next = item.data_byte;
                phase_next  = PH_MLO;
            end
            PH_MLO: begin
                marker_next = (marker_next == MARKER_SYNC && is_sof_low(item.data_byte))
                              ? item.data_byte : 8'h00;
                phase_next  = PH_LHI;
            end
            PH_LHI: begin
                length_next = {item.data_byte, 8'h00};
                phase_next  = PH_LLO;
            end
            PH_LLO: begin
                length_next = len_full;
                if (marker_next != 8'h00) begin
                    phase_next = PH_PREC;
                end else begin
                    // Treat a length below two as two
                    count_next = (len_full < 16'd2) ? 16'd0 : len_full - 16'd2;
                    phase_next = (len_full <= 16'd2) ? PH_MHI : PH_SEGSKIP;
                end
            end
            PH_SEGSKIP: begin
                count_next = cnt_dec;
                if (cnt_dec == 16'd0) begin
                    phase_next = PH_MHI;
                end
            end
            PH_PREC: begin
                precision_next = item.data_byte;
                count_next     = SOF_GAP;
                phase_next     = PH_SOFSKIP;
            end
            PH_SOFSKIP: begin
                count_next = cnt_dec;
                if (cnt_dec == 16'd0) begin
                    phase_next = PH_COMP;
                end
            end
            PH_COMP: begin
                res_valid               = 1'b1;
                res_item.bits_per_pixel = 16'(precision_next) * 16'(item.data_byte);
                res_item.found          = 1'b1;
                done_next               = 1'b1;
                phase_next              = PH_DONE;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        // End of stream: report not found unless a result already went out
        if (item.last_byte) begin
            if (!done_next) begin
                res_valid = 1'b1;
                res_item  = '0;
                done_next = 1'b1;
            end
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP0;
            count_reg     <= '0;
            marker_reg    <= '0;
            length_reg    <= '0;
            precision_reg <= '0;
            done_reg      <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            marker_reg    <= marker_next;
            length_reg    <= length_next;
            precision_reg <= precision_next;
            done_reg      <= done_next;
        end
    end

endmodule

// ===== rtl/jsbd_out_stage.sv =====
// ----------------------------------------------------------------------------
// jsbd_out_stage
// Result register: holds a result until taken and tells the input side when
// it can move.
// ----------------------------------------------------------------------------
module jsbd_out_stage
    import jsbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  logic      res_valid,
    input  out_item_t res_item,
    output logic      advance,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Free when empty or when the held result leaves this cycle
    assign advance = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result only when one is produced
    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            item_reg <= res_item;
        end
    end

endmodule

// ===== rtl/jpeg_sof_bit_depth_scanner.sv =====
// ----------------------------------------------------------------------------
// jpeg_sof_bit_depth_scanner
// Takes one byte per cycle while the result side keeps up, and returns the
// bits per pixel from the start-of-frame segment of a JPEG stream. Each
// byte passes an input register, one parser step and a result register, so
// a result is presented from the result register after its byte has left
// the input register through the parser step. The parser update of a single
// byte is the only loop. An image gives one result: the product of the
// precision and component count bytes, or zero with found low if the last
// byte arrives first.
// ----------------------------------------------------------------------------
module jpeg_sof_bit_depth_scanner
    import jsbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      advance;
    logic      step;
    in_item_t  item;
    logic      res_valid;
    out_item_t res_item;

    jsbd_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .advance (advance),
        .step    (step),
        .item    (item)
    );

    jsbd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    jsbd_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res_item  (res_item),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== rtl/jsbd_checker.sv =====
// ----------------------------------------------------------------------------
// jsbd_checker
// Port-level checks on the scanner, attached by bind.
// ----------------------------------------------------------------------------
module jsbd_checker
    import jsbd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A waiting input item holds its value
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while waiting");

    // A stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // A not-found result carries zero bits per pixel
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.found |-> m_item.bits_per_pixel == 16'd0)
        else $error("not-found result with non-zero depth");

    // A product of two bytes never exceeds 255 squared
    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.found |-> m_item.bits_per_pixel <= 16'd65025)
        else $error("bits per pixel out of range");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

bind jpeg_sof_bit_depth_scanner jsbd_checker u_jsbd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
